### sv/bounded_deque_with_alternate_delete_top_assert.svh
// assertion macros shared by the deque modules
// expects clk and rst in the scope of each use
`ifndef BOUNDED_DEQUE_WITH_ALTERNATE_DELETE_TOP_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_ALTERNATE_DELETE_TOP_ASSERT_SVH

// same-cycle implication
`define BDQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque assertion failed");

// next-cycle implication
`define BDQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque assertion failed");

`endif

### sv/bdq_pkg.sv
// types and codes for the bounded deque
// no dependencies
package bdq_pkg;

  localparam int WORD_W = 32;
  localparam int LEN_W  = 5;
  localparam int KIND_W = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_DELETE_ALT = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    status_t                   status;
    logic [LEN_W-1:0]          length;
    logic signed [WORD_W-1:0]  front_value;
    logic signed [WORD_W-1:0]  back_value;
  } result_t;

endpackage

### sv/bdq_req_if.sv
// request channel of the deque: valid/ready with kind and value
// depends on bdq_pkg
interface bdq_req_if;
  logic                                  valid;
  logic                                  ready;
  logic [bdq_pkg::KIND_W-1:0]            kind;
  logic signed [bdq_pkg::WORD_W-1:0]     value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

### sv/bdq_rsp_if.sv
// response channel of the deque: valid/ready with status, length and end values
// depends on bdq_pkg
interface bdq_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            status;
  logic [bdq_pkg::LEN_W-1:0]             length;
  logic signed [bdq_pkg::WORD_W-1:0]     front_value;
  logic signed [bdq_pkg::WORD_W-1:0]     back_value;

  modport source (output valid, output status, output length, output front_value,
                  output back_value, input ready);
  modport sink   (input valid, input status, input length, input front_value,
                  input back_value, output ready);
endinterface

### sv/bdq_store.sv
// deque storage: front-aligned register array, fill count and next-state logic
// depends on bdq_pkg and the assertion macro header
`include "bounded_deque_with_alternate_delete_top_assert.svh"

module bdq_store #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              step,
  input  logic [bdq_pkg::KIND_W-1:0]        kind,
  input  logic signed [bdq_pkg::WORD_W-1:0] value,
  output bdq_pkg::result_t                  result_next
);
  import bdq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [WORD_W-1:0] entries      [DEPTH];
  logic [WORD_W-1:0] entries_next [DEPTH];
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic              full;
  logic              empty;
  status_t           status;
  logic [WORD_W-1:0] back;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  always_comb begin
    entries_next = entries;
    count_next   = count;
    status       = ST_OK;
    unique case (kind)
      KIND_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          for (int i = 1; i < DEPTH; i++) begin
            entries_next[i] = entries[i-1];
          end
          entries_next[0] = value;
          count_next      = count + CW'(1);
        end
      end
      KIND_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            if (count == CW'(i)) begin
              entries_next[i] = value;
            end
          end
          count_next = count + CW'(1);
        end
      end
      KIND_POP_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          for (int i = 0; i < DEPTH - 1; i++) begin
            entries_next[i] = entries[i+1];
          end
          count_next = count - CW'(1);
        end
      end
      KIND_POP_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          count_next = count - CW'(1);
        end
      end
      KIND_DELETE_ALT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          // keep odd positions, packed toward the front
          for (int i = 0; i < DEPTH / 2; i++) begin
            entries_next[i] = entries[2*i+1];
          end
          count_next = count >> 1;
        end
      end
      default: begin
      end
    endcase
  end

  // back entry sits at count_next - 1
  always_comb begin
    back = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (count_next == CW'(i + 1)) begin
        back = entries_next[i];
      end
    end
  end

  always_comb begin
    result_next.status      = status;
    result_next.length      = LEN_W'(count_next);
    result_next.front_value = (count_next == '0) ? '0 : entries_next[0];
    result_next.back_value  = (count_next == '0) ? '0 : back;
  end

  always_ff @(posedge clk) begin
    if (step) begin
      entries <= entries_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (step) begin
      count <= count_next;
    end
  end

  `BDQ_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(DEPTH))
  `BDQ_ASSERT_NEXT(a_full_push_holds,
                   step && full && (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_BACK),
                   count == $past(count))
  `BDQ_ASSERT_NEXT(a_delete_halves, step && !empty && kind == KIND_DELETE_ALT,
                   count == ($past(count) >> 1))
  `BDQ_ASSERT_NOW(a_empty_status, step && status == ST_EMPTY, empty)

endmodule

### sv/bounded_deque_with_alternate_delete_top.sv
// Bounded deque of DEPTH signed 32-bit words with push/pop at both ends and
// delete-every-other. Each request beat gives one response beat, registered in the
// cycle after acceptance; a request is taken every cycle while the response register
// is empty or being drained, so the rate is one beat per cycle, set by the response
// register handshake. Entries are kept front-aligned in registers; length reports
// the count modulo 32.
// depends on bdq_pkg, bdq_req_if, bdq_rsp_if, bdq_store and the assertion macro header
`include "bounded_deque_with_alternate_delete_top_assert.svh"

module bounded_deque_with_alternate_delete_top #(
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  bdq_req_if.sink    req,
  bdq_rsp_if.source  rsp
);
  import bdq_pkg::*;

  logic    accept;
  logic    rsp_valid;
  result_t result_next;
  result_t result_q;

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  bdq_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk         (clk),
    .rst         (rst),
    .step        (accept),
    .kind        (req.kind),
    .value       (req.value),
    .result_next (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_q <= result_next;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = result_q.status;
  assign rsp.length      = result_q.length;
  assign rsp.front_value = result_q.front_value;
  assign rsp.back_value  = result_q.back_value;

  `BDQ_ASSERT_NEXT(a_accept_loads, accept, rsp_valid)
  `BDQ_ASSERT_NEXT(a_drain_clears, rsp_valid && rsp.ready && !accept, !rsp_valid)

endmodule
